// ===== src/ipd_pkg.sv =====
// Shared types and constants for the +IPD frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

   localparam int unsigned BUFFER_SIZE = 256;
   localparam int unsigned NumMethods  = 5;

   // message class codes
   localparam logic [1:0] MSG_OTHER  = 2'd0;
   localparam logic [1:0] MSG_NATIVE = 2'd1;
   localparam logic [1:0] MSG_HTTP   = 2'd2;

   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_I     = "I";
   localparam logic [7:0] CH_P     = "P";
   localparam logic [7:0] CH_D     = "D";
   localparam logic [7:0] CH_COMMA = ",";
   localparam logic [7:0] CH_COLON = ":";
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_LT    = "<";

   // method patterns, space included: PUT, POST, PATCH, GET, DELETE
   localparam logic [0:4][0:7][7:0] MethodText = '{
      '{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", " ", 8'h00, 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", " ", 8'h00, 8'h00},
      '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", " ", 8'h00}
   };
   localparam logic [0:4][2:0] MethodLen = '{3'd4, 3'd5, 3'd6, 3'd4, 3'd7};

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [7:0]  conn_id;
      logic [15:0] byte_index;
      logic        beyond_buffer;
      logic        last;
      logic [1:0]  msg_class;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/ipd_frame_deframer.sv =====
// Top level of the +IPD frame deframer.
// A payload item accepted on the request side passes the input register, then the
// result register, before it shows on rsp_valid. Header and filler bytes are consumed too.
// Throughput: one item per cycle unless rsp_ready stalls the result register.
// Synchronous active-high reset clears the parse state, the pipeline valids
// and the enable register (bytes ignored until enable is written to 1).
`timescale 1ns / 1ps
`default_nettype none

module ipd_frame_deframer #(
   parameter int unsigned BUFFER_SIZE = ipd_pkg::BUFFER_SIZE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_conn_id,
   output logic [15:0]      rsp_byte_index,
   output logic             rsp_beyond_buffer,
   output logic             rsp_last,
   output logic [1:0]       rsp_msg_class
);

   logic             res_valid;
   logic             res_ready;
   ipd_pkg::rsp_type res;
   ipd_pkg::rsp_type rsp;

   ipd_parser #(
      .BUFFER_SIZE (BUFFER_SIZE)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   ipd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_conn_id       = rsp.conn_id;
   assign rsp_byte_index    = rsp.byte_index;
   assign rsp_beyond_buffer = rsp.beyond_buffer;
   assign rsp_last          = rsp.last;
   assign rsp_msg_class     = rsp.msg_class;

endmodule

`default_nettype wire

// ===== src/ipd_parser.sv =====
// Input register, header state machine and payload classification.
`timescale 1ns / 1ps
`default_nettype none

module ipd_parser #(
   parameter int unsigned BUFFER_SIZE = ipd_pkg::BUFFER_SIZE
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output ipd_pkg::rsp_type      res
);

   typedef enum logic [7:0] {
      PH_SEEK  = 8'b0000_0001,
      PH_I     = 8'b0000_0010,
      PH_P     = 8'b0000_0100,
      PH_D     = 8'b0000_1000,
      PH_COMMA = 8'b0001_0000,
      PH_ID    = 8'b0010_0000,
      PH_LEN   = 8'b0100_0000,
      PH_DATA  = 8'b1000_0000
   } phase_type;

   localparam logic [15:0] BufLimit = 16'(BUFFER_SIZE);

   logic        enable_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  conn_id_ff, conn_id_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] position_ff, position_in;
   logic [7:0]  first_char_ff, first_char_in;
   logic [4:0]  match_ff, match_in;

   logic        step;
   logic        update;
   logic [7:0]  ch;
   logic [7:0]  digit;
   logic        first;
   logic [4:0]  match_cur;
   logic [15:0] rem_dec;
   logic        last;
   logic        http;
   logic [7:0]  fc;
   logic [1:0]  cls;

   assign ch    = in_byte_ff;
   assign digit = ch - ipd_pkg::CH_ZERO;

   assign res_valid = in_valid_ff && enable_ff && (phase_ff == PH_DATA);
   assign step      = in_valid_ff && (!res_valid || res_ready);
   assign update    = step && enable_ff;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   // payload byte bookkeeping
   always_comb begin
      first     = (position_ff == 16'd0);
      match_cur = first ? 5'b11111 : match_ff;
      for (int m = 0; m < ipd_pkg::NumMethods; m++) begin
         if (position_ff < {13'd0, ipd_pkg::MethodLen[m]} &&
             ipd_pkg::MethodText[m][position_ff[2:0]] != ch) begin
            match_cur[m] = 1'b0;
         end
      end
      http = 1'b0;
      for (int m = 0; m < ipd_pkg::NumMethods; m++) begin
         // pattern counts only once all its bytes have arrived
         if (match_cur[m] &&
             ({14'd0, ipd_pkg::MethodLen[m]} <= ({1'b0, position_ff} + 17'd1))) begin
            http = 1'b1;
         end
      end
      rem_dec = remaining_ff - 16'd1;
      last    = (rem_dec == 16'd0);
      fc      = first ? ch : first_char_ff;
      cls     = ipd_pkg::MSG_OTHER;
      if (last) begin
         if (http) begin
            cls = ipd_pkg::MSG_HTTP;
         end else if (fc == ipd_pkg::CH_LT) begin
            cls = ipd_pkg::MSG_NATIVE;
         end
      end
   end

   always_comb begin
      res.data_byte     = ch;
      res.conn_id       = conn_id_ff;
      res.byte_index    = position_ff;
      res.beyond_buffer = (position_ff >= BufLimit);
      res.last          = last;
      res.msg_class     = cls;
   end

   always_comb begin
      phase_in      = phase_ff;
      conn_id_in    = conn_id_ff;
      remaining_in  = remaining_ff;
      position_in   = position_ff;
      first_char_in = first_char_ff;
      match_in      = match_ff;
      case (phase_ff)
         PH_SEEK: begin
            conn_id_in   = 8'd0;
            remaining_in = 16'd0;
            if (ch == ipd_pkg::CH_PLUS) begin
               phase_in = PH_I;
            end
         end
         PH_I:     phase_in = (ch == ipd_pkg::CH_I) ? PH_P : PH_SEEK;
         PH_P:     phase_in = (ch == ipd_pkg::CH_P) ? PH_D : PH_SEEK;
         PH_D:     phase_in = (ch == ipd_pkg::CH_D) ? PH_COMMA : PH_SEEK;
         PH_COMMA: phase_in = (ch == ipd_pkg::CH_COMMA) ? PH_ID : PH_SEEK;
         PH_ID: begin
            if (ch == ipd_pkg::CH_COMMA) begin
               phase_in = PH_LEN;
            end else begin
               conn_id_in = {conn_id_ff[4:0], 3'b000} + {conn_id_ff[6:0], 1'b0} + digit;
            end
         end
         PH_LEN: begin
            if (ch == ipd_pkg::CH_COLON) begin
               position_in = 16'd0;
               phase_in    = (remaining_ff == 16'd0) ? PH_SEEK : PH_DATA;
            end else begin
               remaining_in = {remaining_ff[12:0], 3'b000} + {remaining_ff[14:0], 1'b0}
                            + {8'd0, digit};
            end
         end
         PH_DATA: begin
            first_char_in = fc;
            match_in      = match_cur;
            remaining_in  = rem_dec;
            position_in   = position_ff + 16'd1;
            if (last) begin
               phase_in = PH_SEEK;
            end
         end
         default: phase_in = PH_SEEK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         in_valid_ff   <= 1'b0;
         phase_ff      <= PH_SEEK;
         conn_id_ff    <= 8'd0;
         remaining_ff  <= 16'd0;
         position_ff   <= 16'd0;
         first_char_ff <= 8'd0;
         match_ff      <= 5'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (update) begin
            phase_ff      <= phase_in;
            conn_id_ff    <= conn_id_in;
            remaining_ff  <= remaining_in;
            position_ff   <= position_in;
            first_char_ff <= first_char_in;
            match_ff      <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

// ===== src/ipd_rsp_reg.sv =====
// Result register between the parser and the response channel.
`timescale 1ns / 1ps
`default_nettype none

module ipd_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              res_valid,
   output logic                   res_ready,
   input  wire ipd_pkg::rsp_type  res,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ipd_pkg::rsp_type       rsp
);

   logic             valid_ff;
   ipd_pkg::rsp_type data_ff;

   assign res_ready = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         data_ff <= res;
      end
   end

endmodule

`default_nettype wire
